// ----- rtl/laser_heat_fan_off_delay_assert.svh -----
// Assertion macros for the laser heat and fan-off delay block.
// Used by the RTL modules that carry assertions; expects aclk and aresetn in scope.
`ifndef LASER_HEAT_FAN_OFF_DELAY_ASSERT_SVH
`define LASER_HEAT_FAN_OFF_DELAY_ASSERT_SVH

`ifndef SYNTHESIS

`define LHFOD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("laser_heat_fan_off_delay: assertion failed");

`define LHFOD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("laser_heat_fan_off_delay: assertion failed");

`else

`define LHFOD_ASSERT(label, prop)

`define LHFOD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/lhfod_pkg.sv -----
// Package for the laser heat and fan-off delay block: types, codes and constants.
// No dependencies.
`default_nettype none

package lhfod_pkg;

    localparam int unsigned HEAT_PERIOD = 1000;
    localparam int unsigned DIV_BITS    = 32;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_BITS);
    localparam int unsigned PADDR_W     = 5;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_SPEED   = 2'd1,
        ACT_DISABLE = 2'd2,
        ACT_POLL    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_FAN_DISSIPATION = 3'd0,
        REG_AIR_DISSIPATION = 3'd1,
        REG_HEAT_CAP        = 3'd2,
        REG_MIN_FAN_TIME    = 3'd3,
        REG_MAX_FAN_TIME    = 3'd4,
        REG_PIN_OFF_MODE    = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_HEAT_ADD,
        ST_HEAT_SUB,
        ST_DIV,
        ST_CLAMP_LO,
        ST_CLAMP_HI,
        ST_POLL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] fan_dissipation;
        logic [15:0] air_dissipation;
        logic [31:0] heat_cap;
        logic [31:0] min_fan_time;
        logic [31:0] max_fan_time;
        logic        pin_off_level_mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        fan_dissipation:    16'd100,
        air_dissipation:    16'd20,
        heat_cap:           32'd1000000,
        min_fan_time:       32'd1000,
        max_fan_time:       32'd60000,
        pin_off_level_mode: 1'b1
    };

endpackage

`default_nettype wire

// ----- rtl/lhfod_divider.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// Depends on lhfod_pkg and laser_heat_fan_off_delay_assert.svh.
`default_nettype none

module lhfod_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);
    import lhfod_pkg::*;
    `include "laser_heat_fan_off_delay_assert.svh"

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [15:0]          rem_reg, rem_next;
    logic [31:0]          quot_reg, quot_next;
    logic [15:0]          divisor_reg, divisor_next;
    logic [16:0]          trial;
    logic [17:0]          diff;
    logic                 ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    always_comb begin
        trial        = {rem_reg, quot_reg[31]};
        diff         = {1'b0, trial} - {2'b00, divisor_reg};
        ge           = !diff[17];
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            count_next   = DIV_CNT_W'(DIV_BITS - 1);
            rem_next     = '0;
            quot_next    = dividend;
            divisor_next = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[15:0] : trial[15:0];
            quot_next = {quot_reg[30:0], ge};
            if (count_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

    `LHFOD_ASSERT(a_no_restart_while_busy, start |-> !busy_reg)
    `LHFOD_ASSERT(a_done_after_last_step, done_reg |-> $past(busy_reg) && $past(count_reg) == '0)
    `LHFOD_ASSERT_NEXT(a_done_single_pulse, done_reg, !done_reg && !busy_reg)

endmodule

`default_nettype wire

// ----- rtl/lhfod_core.sv -----
// Sequencer and state of the heat tracker: tick clock, heat update, delay and poll.
// Depends on lhfod_pkg, lhfod_divider and laser_heat_fan_off_delay_assert.svh.
`default_nettype none

module lhfod_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire lhfod_pkg::cfg_t cfg,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_action,
    input  wire logic [15:0]   s_speed,
    input  wire logic          s_disable_status,
    input  wire logic          s_pin_enabled,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_stop_done,
    output logic               m_pin_write,
    output logic               m_pin_level,
    output logic [31:0]        m_heat_now,
    output logic [31:0]        m_delay_now
);
    import lhfod_pkg::*;
    `include "laser_heat_fan_off_delay_assert.svh"

    state_t      state_reg, state_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] last_heat_reg, last_heat_next;
    logic [31:0] stamp_reg, stamp_next;
    logic        flag_reg, flag_next;
    logic [31:0] heat_reg, heat_next;
    logic [31:0] delay_reg, delay_next;
    logic [15:0] speed_reg, speed_next;
    logic        pin_on_reg, pin_on_next;
    logic        done_reg, done_next;
    logic        pwrite_reg, pwrite_next;
    logic        plevel_reg, plevel_next;
    logic [31:0] quot_reg, quot_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_stop_done_reg, m_stop_done_next;
    logic        m_pin_write_reg, m_pin_write_next;
    logic        m_pin_level_reg, m_pin_level_next;
    logic [31:0] m_heat_now_reg, m_heat_now_next;
    logic [31:0] m_delay_now_reg, m_delay_now_next;

    logic        div_start;
    logic        div_done;
    logic [31:0] div_quot;
    logic [31:0] elapsed;
    logic [32:0] heat_sum;
    logic [31:0] dissipation;

    lhfod_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (heat_reg),
        .divisor  (cfg.fan_dissipation),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tick_reg      <= '0;
            last_heat_reg <= '0;
            stamp_reg     <= '0;
            flag_reg      <= 1'b0;
            heat_reg      <= '0;
            delay_reg     <= '0;
            speed_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            last_heat_reg <= last_heat_next;
            stamp_reg     <= stamp_next;
            flag_reg      <= flag_next;
            heat_reg      <= heat_next;
            delay_reg     <= delay_next;
            speed_reg     <= speed_next;
            m_valid_reg   <= m_valid_next;
        end
        pin_on_reg      <= pin_on_next;
        done_reg        <= done_next;
        pwrite_reg      <= pwrite_next;
        plevel_reg      <= plevel_next;
        quot_reg        <= quot_next;
        m_stop_done_reg <= m_stop_done_next;
        m_pin_write_reg <= m_pin_write_next;
        m_pin_level_reg <= m_pin_level_next;
        m_heat_now_reg  <= m_heat_now_next;
        m_delay_now_reg <= m_delay_now_next;
    end

    always_comb begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        last_heat_next   = last_heat_reg;
        stamp_next       = stamp_reg;
        flag_next        = flag_reg;
        heat_next        = heat_reg;
        delay_next       = delay_reg;
        speed_next       = speed_reg;
        pin_on_next      = pin_on_reg;
        done_next        = done_reg;
        pwrite_next      = pwrite_reg;
        plevel_next      = plevel_reg;
        quot_next        = quot_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_stop_done_next = m_stop_done_reg;
        m_pin_write_next = m_pin_write_reg;
        m_pin_level_next = m_pin_level_reg;
        m_heat_now_next  = m_heat_now_reg;
        m_delay_now_next = m_delay_now_reg;
        s_ready          = 1'b0;
        div_start        = 1'b0;
        elapsed          = '0;
        heat_sum         = '0;
        dissipation      = '0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    done_next   = 1'b0;
                    pwrite_next = 1'b0;
                    plevel_next = 1'b0;
                    case (s_action)
                        ACT_TICK: begin
                            tick_next   = tick_reg + 32'd1;
                            pin_on_next = s_pin_enabled;
                            state_next  = ST_TICK;
                        end
                        ACT_SPEED: begin
                            speed_next = s_speed;
                            stamp_next = tick_reg;
                            state_next = ST_OUT;
                        end
                        ACT_DISABLE: begin
                            flag_next  = s_disable_status;
                            stamp_next = tick_reg;
                            if (!s_disable_status) begin
                                state_next = ST_OUT;
                            end else if (cfg.fan_dissipation == '0) begin
                                quot_next  = '1;
                                state_next = ST_CLAMP_LO;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        ACT_POLL: begin
                            state_next = ST_POLL;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                elapsed = tick_reg - last_heat_reg;
                if (elapsed >= 32'(HEAT_PERIOD)) begin
                    last_heat_next = tick_reg;
                    state_next     = ST_HEAT_ADD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_HEAT_ADD: begin
                heat_sum = {1'b0, heat_reg} + {17'd0, speed_reg};
                if (pin_on_reg && (heat_reg < cfg.heat_cap)) begin
                    heat_next = heat_sum[32] ? '1 : heat_sum[31:0];
                end
                state_next = ST_HEAT_SUB;
            end
            ST_HEAT_SUB: begin
                dissipation = pin_on_reg ? {16'd0, cfg.fan_dissipation}
                                         : {16'd0, cfg.air_dissipation};
                if (heat_reg >= dissipation) begin
                    heat_next = heat_reg - dissipation;
                end
                state_next = ST_OUT;
            end
            ST_DIV: begin
                if (div_done) begin
                    quot_next  = div_quot;
                    state_next = ST_CLAMP_LO;
                end
            end
            ST_CLAMP_LO: begin
                if (quot_reg < cfg.min_fan_time) begin
                    quot_next = cfg.min_fan_time;
                end
                state_next = ST_CLAMP_HI;
            end
            ST_CLAMP_HI: begin
                delay_next = (quot_reg > cfg.max_fan_time) ? cfg.max_fan_time : quot_reg;
                state_next = ST_OUT;
            end
            ST_POLL: begin
                elapsed   = tick_reg - stamp_reg;
                done_next = 1'b1;
                if (flag_reg) begin
                    if (elapsed > delay_reg) begin
                        flag_next   = 1'b0;
                        heat_next   = '0;
                        pwrite_next = 1'b1;
                        plevel_next = !cfg.pin_off_level_mode;
                    end else begin
                        done_next = 1'b0;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_stop_done_next = done_reg;
                    m_pin_write_next = pwrite_reg;
                    m_pin_level_next = plevel_reg;
                    m_heat_now_next  = heat_reg;
                    m_delay_now_next = delay_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_stop_done = m_stop_done_reg;
    assign m_pin_write = m_pin_write_reg;
    assign m_pin_level = m_pin_level_reg;
    assign m_heat_now  = m_heat_now_reg;
    assign m_delay_now = m_delay_now_reg;

    `LHFOD_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != ST_IDLE)
    `LHFOD_ASSERT_NEXT(a_div_start_enters_div, div_start, state_reg == ST_DIV)
    `LHFOD_ASSERT(a_pin_write_implies_done, m_valid_reg && m_pin_write_reg |-> m_stop_done_reg)

endmodule

`default_nettype wire

// ----- rtl/laser_heat_fan_off_delay.sv -----
// Top level of the laser heat and fan-off delay block: configuration registers and core.
// Depends on lhfod_pkg, lhfod_core and lhfod_divider.
//
// Usage: one transaction on the s_ channel carries an action (tick, speed update,
// disable flag write or poll) and gives exactly one result transaction on the m_ channel
// with the poll answer, an optional enable pin drive, the heat and the fan-off delay.
// The block takes one transaction at a time and holds s_ready low while it works.
// A speed update or a cleared disable flag goes straight to the output register; a poll
// passes the poll state first, a tick the tick state and, when a heat update falls due,
// the heat add and subtract states. Setting the disable flag runs the restoring divider,
// one quotient bit per cycle, then the low and high clamp states (no divider with a zero
// fan dissipation); the divider loop sets the worst case; s_ready rises with m_valid.
// The result sits in an output register, so a new transaction is accepted while the
// previous result still waits; if the receiver stalls, the next result waits in the
// sequencer and s_ready stays low until the output register frees.
// The APB port writes the six configuration registers at byte addresses 0 to 20.
// Reset is synchronous and active low; it clears the sequencer state, the tick counter
// and the heat, empties the result register and loads the configuration defaults.
`default_nettype none

module laser_heat_fan_off_delay (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lhfod_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_action,
    input  wire logic [15:0]                   s_speed,
    input  wire logic                          s_disable_status,
    input  wire logic                          s_pin_enabled,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_stop_done,
    output logic                               m_pin_write,
    output logic                               m_pin_level,
    output logic [31:0]                        m_heat_now,
    output logic [31:0]                        m_delay_now
);
    import lhfod_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_FAN_DISSIPATION: cfg_next.fan_dissipation    = pwdata[15:0];
                REG_AIR_DISSIPATION: cfg_next.air_dissipation    = pwdata[15:0];
                REG_HEAT_CAP:        cfg_next.heat_cap           = pwdata;
                REG_MIN_FAN_TIME:    cfg_next.min_fan_time       = pwdata;
                REG_MAX_FAN_TIME:    cfg_next.max_fan_time       = pwdata;
                REG_PIN_OFF_MODE:    cfg_next.pin_off_level_mode = pwdata[0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_FAN_DISSIPATION: prdata = {16'd0, cfg_reg.fan_dissipation};
            REG_AIR_DISSIPATION: prdata = {16'd0, cfg_reg.air_dissipation};
            REG_HEAT_CAP:        prdata = cfg_reg.heat_cap;
            REG_MIN_FAN_TIME:    prdata = cfg_reg.min_fan_time;
            REG_MAX_FAN_TIME:    prdata = cfg_reg.max_fan_time;
            REG_PIN_OFF_MODE:    prdata = {31'd0, cfg_reg.pin_off_level_mode};
            default:             prdata = '0;
        endcase
    end

    lhfod_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_speed          (s_speed),
        .s_disable_status (s_disable_status),
        .s_pin_enabled    (s_pin_enabled),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_stop_done      (m_stop_done),
        .m_pin_write      (m_pin_write),
        .m_pin_level      (m_pin_level),
        .m_heat_now       (m_heat_now),
        .m_delay_now      (m_delay_now)
    );

endmodule

`default_nettype wire
